### design/mas_pkg.sv
// Shared types and constants of the perceptron anomaly scorer.
package mas_pkg;

    localparam int MAX_INPUT    = 256;
    localparam int MAX_HIDDEN1  = 128;
    localparam int MAX_HIDDEN2  = 64;
    localparam int IN_AW        = $clog2(MAX_INPUT);
    localparam int H1_AW        = $clog2(MAX_HIDDEN1);
    localparam int H2_AW        = $clog2(MAX_HIDDEN2);
    localparam int ACC_W        = 44;
    localparam int Q_W          = ACC_W - 12;

    localparam logic [1:0] CMD_WEIGHT  = 2'd0;
    localparam logic [1:0] CMD_BIAS    = 2'd1;
    localparam logic [1:0] CMD_FEATURE = 2'd2;

    localparam logic [1:0] LAYER_FIRST  = 2'd0;
    localparam logic [1:0] LAYER_SECOND = 2'd1;
    localparam logic [1:0] LAYER_OUTPUT = 2'd2;

    localparam logic [1:0] REG_INPUT_LENGTH    = 2'd0;
    localparam logic [1:0] REG_HIDDEN1_WIDTH   = 2'd1;
    localparam logic [1:0] REG_HIDDEN2_WIDTH   = 2'd2;
    localparam logic [1:0] REG_LOGIT_THRESHOLD = 2'd3;

    typedef struct packed {
        logic [1:0]         command;
        logic [1:0]         layer;
        logic [6:0]         neuron;
        logic [7:0]         position;
        logic signed [15:0] value;
    } in_item_t;

    typedef struct packed {
        logic signed [23:0] logit;
        logic               anomaly;
    } out_item_t;

    typedef struct packed {
        logic               load_we;
        logic               feat_we;
        logic [IN_AW-1:0]   feat_addr;
        logic [1:0]         layer;
        logic [7:0]         neuron;
        logic [8:0]         tap;
        logic               bias_rd;
        logic               mac_rd;
        logic               store;
        logic signed [23:0] threshold;
    } ctl_cmd_t;

endpackage

### design/mas_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mas_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### design/mas_ctrl.sv
// Controller of the scorer: configuration registers, window count and layer sequencer.
module mas_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  mas_pkg::in_item_t item,
    output logic              busy,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [23:0]       cfg_data,
    output mas_pkg::ctl_cmd_t cmd
);
    import mas_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_BIAS  = 5'b00010,
        S_MAC   = 5'b00100,
        S_DRAIN = 5'b01000,
        S_STORE = 5'b10000
    } state_t;

    state_t             state_reg, state_next;
    logic [8:0]         len_reg;
    logic [7:0]         h1_reg;
    logic [6:0]         h2_reg;
    logic signed [23:0] thr_reg;
    logic [8:0]         count_reg, count_next;
    logic [1:0]         layer_reg, layer_next;
    logic [7:0]         j_reg, j_next;
    logic [8:0]         k_reg, k_next;
    logic [1:0]         drain_reg, drain_next;
    logic [8:0]         n0, n1, n2;
    logic [8:0]         fan_in;
    logic [8:0]         neurons;
    logic               accept;

    assign cfg_ready = 1'b1;
    assign busy      = (state_reg != S_IDLE);
    assign accept    = start && !busy;

    always_comb
    begin
        n0 = (len_reg == 9'd0) ? 9'd1 :
             (len_reg > 9'(MAX_INPUT)) ? 9'(MAX_INPUT) : len_reg;
        n1 = (h1_reg == 8'd0) ? 9'd1 :
             ({1'b0, h1_reg} > 9'(MAX_HIDDEN1)) ? 9'(MAX_HIDDEN1) : {1'b0, h1_reg};
        n2 = (h2_reg == 7'd0) ? 9'd1 :
             ({2'b0, h2_reg} > 9'(MAX_HIDDEN2)) ? 9'(MAX_HIDDEN2) : {2'b0, h2_reg};
        case (layer_reg)
            LAYER_FIRST:
            begin
                fan_in  = n0;
                neurons = n1;
            end
            LAYER_SECOND:
            begin
                fan_in  = n1;
                neurons = n2;
            end
            default:
            begin
                fan_in  = n2;
                neurons = 9'd1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= 9'd200;
            h1_reg  <= 8'd128;
            h2_reg  <= 7'd64;
            thr_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_INPUT_LENGTH:    len_reg <= cfg_data[8:0];
                REG_HIDDEN1_WIDTH:   h1_reg  <= cfg_data[7:0];
                REG_HIDDEN2_WIDTH:   h2_reg  <= cfg_data[6:0];
                REG_LOGIT_THRESHOLD: thr_reg <= cfg_data;
                default:             thr_reg <= thr_reg;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        layer_next = layer_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        drain_next = drain_reg;
        cmd            = '0;
        cmd.layer      = layer_reg;
        cmd.neuron     = j_reg;
        cmd.tap        = k_reg;
        cmd.threshold  = thr_reg;
        cmd.feat_addr  = count_reg[IN_AW-1:0];
        cmd.load_we    = accept && (item.command == CMD_WEIGHT || item.command == CMD_BIAS);
        case (state_reg)
            S_IDLE:
            begin
                if (accept && item.command == CMD_FEATURE)
                begin
                    cmd.feat_we = (count_reg < 9'(MAX_INPUT));
                    if (count_reg + 9'd1 >= n0)
                    begin
                        count_next = '0;
                        layer_next = LAYER_FIRST;
                        j_next     = '0;
                        state_next = S_BIAS;
                    end
                    else
                    begin
                        count_next = count_reg + 9'd1;
                    end
                end
            end
            S_BIAS:
            begin
                cmd.bias_rd = 1'b1;
                k_next      = '0;
                state_next  = S_MAC;
            end
            S_MAC:
            begin
                cmd.mac_rd = 1'b1;
                if (k_reg + 9'd1 >= fan_in)
                begin
                    drain_next = '0;
                    state_next = S_DRAIN;
                end
                else
                begin
                    k_next = k_reg + 9'd1;
                end
            end
            S_DRAIN:
            begin
                drain_next = drain_reg + 2'd1;
                if (drain_reg == 2'd1)
                begin
                    state_next = S_STORE;
                end
            end
            S_STORE:
            begin
                cmd.store = 1'b1;
                if ({1'b0, j_reg} + 9'd1 < neurons)
                begin
                    j_next     = j_reg + 8'd1;
                    state_next = S_BIAS;
                end
                else if (layer_reg == LAYER_OUTPUT)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    j_next     = '0;
                    layer_next = layer_reg + 2'd1;
                    state_next = S_BIAS;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            layer_reg <= LAYER_FIRST;
            j_reg     <= '0;
            k_reg     <= '0;
            drain_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            layer_reg <= layer_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            drain_reg <= drain_next;
        end
    end

endmodule

### design/mas_datapath.sv
// Datapath of the scorer: weight, bias and activation stores, one MAC unit, rounding.
module mas_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  mas_pkg::in_item_t  item,
    input  mas_pkg::ctl_cmd_t  cmd,
    output mas_pkg::out_item_t result,
    output logic               result_valid
);
    import mas_pkg::*;

    logic               w1_we, w2_we, wo_we, b1_we, b2_we, bo_we;
    logic [15:0]        w1_rd, w2_rd, wo_rd, b1_rd, b2_rd, win_rd, h1_rd, h2_rd;
    logic [15:0]        bo_reg;
    logic [15:0]        act_val;
    logic               h1_we, h2_we;
    logic               bias_v_reg, mac_v1_reg, mac_v2_reg;
    logic [1:0]         lay_d_reg;
    logic signed [31:0] prod_reg;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [15:0] w_sel, a_sel, b_sel;
    logic signed [ACC_W-1:0] rnd;
    logic signed [Q_W-1:0]   q;
    logic signed [23:0] logit_sat;
    logic               valid_reg;
    out_item_t          result_reg;

    always_comb
    begin
        w1_we = 1'b0;
        w2_we = 1'b0;
        wo_we = 1'b0;
        b1_we = 1'b0;
        b2_we = 1'b0;
        bo_we = 1'b0;
        if (cmd.load_we)
        begin
            if (item.command == CMD_WEIGHT)
            begin
                case (item.layer)
                    LAYER_FIRST:  w1_we = 1'b1;
                    LAYER_SECOND: w2_we = ({1'b0, item.neuron} < 8'(MAX_HIDDEN2)) &&
                                          ({1'b0, item.position} < 9'(MAX_HIDDEN1));
                    LAYER_OUTPUT: wo_we = (item.neuron == 7'd0) &&
                                          ({1'b0, item.position} < 9'(MAX_HIDDEN2));
                    default:      w1_we = 1'b0;
                endcase
            end
            else
            begin
                case (item.layer)
                    LAYER_FIRST:  b1_we = 1'b1;
                    LAYER_SECOND: b2_we = ({1'b0, item.neuron} < 8'(MAX_HIDDEN2));
                    LAYER_OUTPUT: bo_we = (item.neuron == 7'd0);
                    default:      b1_we = 1'b0;
                endcase
            end
        end
    end

    assign h1_we = cmd.store && (cmd.layer == LAYER_FIRST);
    assign h2_we = cmd.store && (cmd.layer == LAYER_SECOND);

    mas_ram #(.WIDTH(16), .DEPTH(MAX_HIDDEN1 * MAX_INPUT)) u_w1 (
        .clk(clk), .we(w1_we),
        .waddr({item.neuron[H1_AW-1:0], item.position[IN_AW-1:0]}),
        .wdata(item.value),
        .raddr({cmd.neuron[H1_AW-1:0], cmd.tap[IN_AW-1:0]}),
        .rdata(w1_rd)
    );

    mas_ram #(.WIDTH(16), .DEPTH(MAX_HIDDEN2 * MAX_HIDDEN1)) u_w2 (
        .clk(clk), .we(w2_we),
        .waddr({item.neuron[H2_AW-1:0], item.position[H1_AW-1:0]}),
        .wdata(item.value),
        .raddr({cmd.neuron[H2_AW-1:0], cmd.tap[H1_AW-1:0]}),
        .rdata(w2_rd)
    );

    mas_ram #(.WIDTH(16), .DEPTH(MAX_HIDDEN2)) u_wo (
        .clk(clk), .we(wo_we),
        .waddr(item.position[H2_AW-1:0]), .wdata(item.value),
        .raddr(cmd.tap[H2_AW-1:0]), .rdata(wo_rd)
    );

    mas_ram #(.WIDTH(16), .DEPTH(MAX_HIDDEN1)) u_b1 (
        .clk(clk), .we(b1_we),
        .waddr(item.neuron[H1_AW-1:0]), .wdata(item.value),
        .raddr(cmd.neuron[H1_AW-1:0]), .rdata(b1_rd)
    );

    mas_ram #(.WIDTH(16), .DEPTH(MAX_HIDDEN2)) u_b2 (
        .clk(clk), .we(b2_we),
        .waddr(item.neuron[H2_AW-1:0]), .wdata(item.value),
        .raddr(cmd.neuron[H2_AW-1:0]), .rdata(b2_rd)
    );

    mas_ram #(.WIDTH(16), .DEPTH(MAX_INPUT)) u_win (
        .clk(clk), .we(cmd.feat_we),
        .waddr(cmd.feat_addr), .wdata(item.value),
        .raddr(cmd.tap[IN_AW-1:0]), .rdata(win_rd)
    );

    mas_ram #(.WIDTH(16), .DEPTH(MAX_HIDDEN1)) u_h1 (
        .clk(clk), .we(h1_we),
        .waddr(cmd.neuron[H1_AW-1:0]), .wdata(act_val),
        .raddr(cmd.tap[H1_AW-1:0]), .rdata(h1_rd)
    );

    mas_ram #(.WIDTH(16), .DEPTH(MAX_HIDDEN2)) u_h2 (
        .clk(clk), .we(h2_we),
        .waddr(cmd.neuron[H2_AW-1:0]), .wdata(act_val),
        .raddr(cmd.tap[H2_AW-1:0]), .rdata(h2_rd)
    );

    always_ff @(posedge clk)
    begin
        if (bo_we)
        begin
            bo_reg <= item.value;
        end
    end

    always_comb
    begin
        case (lay_d_reg)
            LAYER_FIRST:
            begin
                w_sel = w1_rd;
                a_sel = win_rd;
                b_sel = b1_rd;
            end
            LAYER_SECOND:
            begin
                w_sel = w2_rd;
                a_sel = h1_rd;
                b_sel = b2_rd;
            end
            default:
            begin
                w_sel = wo_rd;
                a_sel = h2_rd;
                b_sel = bo_reg;
            end
        endcase
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (bias_v_reg)
        begin
            acc_next = ACC_W'(b_sel) <<< 12;
        end
        else if (mac_v2_reg)
        begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end
    end

    always_comb
    begin
        rnd = acc_reg + ACC_W'(2048);
        q   = Q_W'(rnd >>> 12);
        if (q < 0)
        begin
            act_val = 16'd0;
        end
        else if (q > Q_W'(32767))
        begin
            act_val = 16'd32767;
        end
        else
        begin
            act_val = q[15:0];
        end
        if (q > Q_W'(8388607))
        begin
            logit_sat = 24'sd8388607;
        end
        else if (q < -Q_W'(8388608))
        begin
            logit_sat = -24'sd8388608;
        end
        else
        begin
            logit_sat = q[23:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bias_v_reg <= 1'b0;
            mac_v1_reg <= 1'b0;
            mac_v2_reg <= 1'b0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            bias_v_reg <= cmd.bias_rd;
            mac_v1_reg <= cmd.mac_rd;
            mac_v2_reg <= mac_v1_reg;
            valid_reg  <= cmd.store && (cmd.layer == LAYER_OUTPUT);
        end
    end

    always_ff @(posedge clk)
    begin
        lay_d_reg <= cmd.layer;
        prod_reg  <= w_sel * a_sel;
        acc_reg   <= acc_next;
        if (cmd.store && cmd.layer == LAYER_OUTPUT)
        begin
            result_reg.logit   <= logit_sat;
            result_reg.anomaly <= (logit_sat >= cmd.threshold);
        end
    end

    assign result       = result_reg;
    assign result_valid = valid_reg;

endmodule

### design/mlp_anomaly_scorer.sv
// Top level of the three-layer perceptron anomaly scorer.
// Weight, bias and feature beats are taken one per cycle while busy is low. The feature
// beat that completes a window raises busy while the single MAC unit walks every weight
// row of the three layers in turn, with n0, n1, n2 the clamped layer sizes. The result
// then appears on result for one cycle with result_valid high and cannot be held off,
// so it must be taken then.
module mlp_anomaly_scorer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  mas_pkg::in_item_t   item,
    output mas_pkg::out_item_t  result,
    output logic                result_valid,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [23:0]         cfg_data
);
    import mas_pkg::*;

    ctl_cmd_t cmd;

    mas_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .item(item), .busy(busy),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .cmd(cmd)
    );

    mas_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .item(item), .cmd(cmd),
        .result(result), .result_valid(result_valid)
    );

endmodule
